[hdl/rpkd_pkg.sv]
package rpkd_pkg;

    localparam int DataWidth = 32;
    localparam int ProdWidth = 2 * DataWidth;
    localparam int CoefWidth = DataWidth + 2;
    localparam int InWidth = 16;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_SMALL_FACTOR = 2'd1,
        ST_EXP_RANGE    = 2'd2,
        ST_NOT_COPRIME  = 2'd3
    } status_t;

    typedef struct packed {
        logic                 start;
        logic [DataWidth-1:0] a;
        logic [DataWidth-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                 done;
        logic [ProdWidth-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic                 start;
        logic [DataWidth-1:0] dividend;
        logic [DataWidth-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DataWidth-1:0] quotient;
        logic [DataWidth-1:0] remainder;
    } div_rsp_t;

endpackage

[hdl/rpkd_multiplier.sv]
module rpkd_multiplier (
    input  logic               aclk,
    input  logic               aresetn,
    input  rpkd_pkg::mul_req_t req,
    output rpkd_pkg::mul_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic [rpkd_pkg::ProdWidth-1:0] acc_reg, acc_next;
    logic [rpkd_pkg::ProdWidth-1:0] mcand_reg, mcand_next;
    logic [rpkd_pkg::DataWidth-1:0] mplier_reg, mplier_next;

    always_comb begin
        busy_next   = busy_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (req.start) begin
            busy_next   = 1'b1;
            acc_next    = '0;
            mcand_next  = {{rpkd_pkg::DataWidth{1'b0}}, req.a};
            mplier_next = req.b;
        end else if (busy_reg) begin
            if (mplier_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[rpkd_pkg::ProdWidth-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[rpkd_pkg::DataWidth-1:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign rsp.done    = busy_reg && (mplier_reg == '0);
    assign rsp.product = acc_reg;

endmodule

[hdl/rpkd_divider.sv]
module rpkd_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  rpkd_pkg::div_req_t req,
    output rpkd_pkg::div_rsp_t rsp
);

    localparam int CntWidth = $clog2(rpkd_pkg::DataWidth);
    localparam logic [CntWidth-1:0] LastStep = CntWidth'(rpkd_pkg::DataWidth - 1);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [CntWidth-1:0]            cnt_reg, cnt_next;
    logic [rpkd_pkg::DataWidth-1:0] rem_reg, rem_next;
    logic [rpkd_pkg::DataWidth-1:0] quo_reg, quo_next;
    logic [rpkd_pkg::DataWidth-1:0] dsr_reg, dsr_next;
    logic [rpkd_pkg::DataWidth:0]   shifted;
    logic [rpkd_pkg::DataWidth:0]   trial;

    assign shifted = {rem_reg, quo_reg[rpkd_pkg::DataWidth-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            if (!trial[rpkd_pkg::DataWidth]) begin
                rem_next = trial[rpkd_pkg::DataWidth-1:0];
                quo_next = {quo_reg[rpkd_pkg::DataWidth-2:0], 1'b1};
            end else begin
                rem_next = shifted[rpkd_pkg::DataWidth-1:0];
                quo_next = {quo_reg[rpkd_pkg::DataWidth-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LastStep) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

[hdl/rsa_private_key_derivation_unit.sv]
// RSA private exponent derivation unit.
// One beat on the s_ channel carries primes p and q and a public exponent e.
// The unit returns one beat on the m_ channel with d = e^-1 mod (p-1)(q-1),
// the modulus n = p*q and a status (0 ok, 1 factor below two, 2 exponent out
// of range, 3 exponent not coprime to the totient; d is zero unless ok).
// Both channels use valid/ready; a beat moves when valid and ready are high.
// One item is worked at a time and s_ready is low while it is in progress.
// Work runs as steps: n, then the totient and the checks, then one extended
// Euclid step per quotient, each on the bit-serial divider and then on the
// shift-add multiplier shared for all products, which forms the quotient
// times the magnitude of the current Bezout coefficient t.
// The finished result sits in an output register; if the receiver stalls,
// a new item may still be accepted and is held in its final state until the
// register frees up.
// Reset (aresetn low, synchronous) returns the unit to idle and drops m_valid.
module rsa_private_key_derivation_unit #(
    parameter int PRIME_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_prime_p,
    input  logic [15:0] s_prime_q,
    input  logic [31:0] s_public_exponent,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_private_exponent,
    output logic [31:0] m_modulus,
    output logic [1:0]  m_status
);

    localparam int DW = rpkd_pkg::DataWidth;
    localparam int CW = rpkd_pkg::CoefWidth;
    localparam int IW = rpkd_pkg::InWidth;
    localparam int FactorWidth = (PRIME_WIDTH < IW) ? PRIME_WIDTH : IW;
    localparam logic [IW-1:0] FactorMask = IW'((33'd1 << FactorWidth) - 33'd1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_N, S_MUL_PHI, S_CHECK, S_LOOP, S_DIV, S_MUL_T,
        S_RESOLVE, S_FIXUP, S_FINISH
    } state_t;

    state_t                 state_reg;
    logic [IW-1:0]          p_reg, q_reg;
    logic [DW-1:0]          e_reg;
    logic [DW-1:0]          n_reg;
    logic [DW-1:0]          phi_reg;
    logic [DW-1:0]          r0_reg, r1_reg, rn_reg;
    logic signed [CW-1:0]   t0_reg, t1_reg;
    logic [DW-1:0]          d_reg;
    rpkd_pkg::status_t      status_reg;
    logic                   m_valid_reg;
    logic [DW-1:0]          m_d_reg, m_n_reg;
    rpkd_pkg::status_t      m_status_reg;

    rpkd_pkg::mul_req_t     mul_req;
    rpkd_pkg::mul_rsp_t     mul_rsp;
    rpkd_pkg::div_req_t     div_req;
    rpkd_pkg::div_rsp_t     div_rsp;

    logic                   small_factor;
    logic [DW-1:0]          t1_mag;
    logic signed [CW-1:0]   prod_s;
    logic signed [CW-1:0]   tn;
    logic signed [CW-1:0]   d_wide;
    logic                   out_free;

    assign small_factor = (p_reg < IW'(2)) || (q_reg < IW'(2));
    assign t1_mag = t1_reg[CW-1] ? DW'(-t1_reg) : DW'(t1_reg);
    assign prod_s = $signed(mul_rsp.product[CW-1:0]);
    assign tn = t1_reg[CW-1] ? (t0_reg + prod_s) : (t0_reg - prod_s);
    assign d_wide = t0_reg[CW-1] ? (t0_reg + $signed({2'b00, phi_reg})) : t0_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        mul_req = '0;
        div_req = '0;
        unique case (state_reg)
            S_IDLE: begin
                mul_req.start = s_valid;
                mul_req.a = DW'(s_prime_p & FactorMask);
                mul_req.b = DW'(s_prime_q & FactorMask);
            end
            S_MUL_N: begin
                mul_req.start = mul_rsp.done && !small_factor;
                mul_req.a = DW'(p_reg - IW'(1));
                mul_req.b = DW'(q_reg - IW'(1));
            end
            S_LOOP: begin
                div_req.start = (r1_reg != '0);
                div_req.dividend = r0_reg;
                div_req.divisor = r1_reg;
            end
            S_DIV: begin
                mul_req.start = div_rsp.done;
                mul_req.a = div_rsp.quotient;
                mul_req.b = t1_mag;
            end
            default: begin
            end
        endcase
    end

    rpkd_multiplier u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    rpkd_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == S_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        p_reg      <= s_prime_p & FactorMask;
                        q_reg      <= s_prime_q & FactorMask;
                        e_reg      <= s_public_exponent;
                        d_reg      <= '0;
                        status_reg <= rpkd_pkg::ST_OK;
                        state_reg  <= S_MUL_N;
                    end
                end
                S_MUL_N: begin
                    if (mul_rsp.done) begin
                        n_reg <= mul_rsp.product[DW-1:0];
                        if (small_factor) begin
                            status_reg <= rpkd_pkg::ST_SMALL_FACTOR;
                            state_reg  <= S_FINISH;
                        end else begin
                            state_reg <= S_MUL_PHI;
                        end
                    end
                end
                S_MUL_PHI: begin
                    if (mul_rsp.done) begin
                        phi_reg   <= mul_rsp.product[DW-1:0];
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (e_reg == '0 || e_reg >= phi_reg) begin
                        status_reg <= rpkd_pkg::ST_EXP_RANGE;
                        state_reg  <= S_FINISH;
                    end else begin
                        r0_reg    <= phi_reg;
                        r1_reg    <= e_reg;
                        t0_reg    <= '0;
                        t1_reg    <= CW'(1);
                        state_reg <= S_LOOP;
                    end
                end
                S_LOOP: begin
                    state_reg <= (r1_reg != '0) ? S_DIV : S_RESOLVE;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        rn_reg    <= div_rsp.remainder;
                        state_reg <= S_MUL_T;
                    end
                end
                S_MUL_T: begin
                    if (mul_rsp.done) begin
                        r0_reg    <= r1_reg;
                        r1_reg    <= rn_reg;
                        t0_reg    <= t1_reg;
                        t1_reg    <= tn;
                        state_reg <= S_LOOP;
                    end
                end
                S_RESOLVE: begin
                    if (r0_reg != DW'(1)) begin
                        status_reg <= rpkd_pkg::ST_NOT_COPRIME;
                        state_reg  <= S_FINISH;
                    end else begin
                        d_reg     <= d_wide[DW-1:0];
                        state_reg <= S_FIXUP;
                    end
                end
                S_FIXUP: begin
                    if (d_reg >= phi_reg) begin
                        d_reg <= d_reg - phi_reg;
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_d_reg      <= d_reg;
                        m_n_reg      <= n_reg;
                        m_status_reg <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready            = (state_reg == S_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_private_exponent = m_d_reg;
    assign m_modulus          = m_n_reg;
    assign m_status           = m_status_reg;

endmodule
